FILE: rtl/sobel_edge_magnitude_assert.svh
// assertion macros for the sobel edge magnitude block
`ifndef SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_ASSERT_SVH
`ifndef SYNTH
`define SEM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sobel edge magnitude: implication failed");
`define SEM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sobel edge magnitude: next-cycle check failed");
`else
`define SEM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SEM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/sem_pkg.sv
// shared types and constants for the sobel edge magnitude block
`default_nettype none
package sem_pkg;
  localparam int DEFAULT_MAX_WIDTH = 2048;
  localparam int LUMA_W    = 18;
  localparam int ALPHA_W   = 8;
  localparam int WORD_W    = LUMA_W + ALPHA_W;
  localparam int ROW_W     = 16;
  localparam int COL_W     = 12;
  localparam int OUT_COL_W = 11;
  localparam int HGT_W     = 16;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int GRAD_W    = 20;
  localparam int SUM_W     = 41;
  localparam int ROOT_W    = 21;
  localparam int REM_W     = 23;
  localparam int DIV_SH    = 28;

  localparam logic [8:0]  Y_R = 9'd299;
  localparam logic [9:0]  Y_G = 10'd587;
  localparam logic [6:0]  Y_B = 7'd114;
  localparam logic [18:0] DIV_K = 19'd268436;
  localparam logic [ROOT_W-1:0] CAP_LIMIT = 21'd256000;
  localparam logic [COL_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [HGT_W-1:0] HEIGHT_RESET = 16'd480;

  typedef enum logic {REG_WIDTH = 1'b0, REG_HEIGHT = 1'b1} reg_idx_e;
  typedef enum logic [1:0] {F_IDLE, F_SHIFT, F_EMIT} front_state_e;
  typedef enum logic [2:0] {B_IDLE, B_GRAD, B_SQR, B_ROOT, B_DIV, B_SCALE} back_state_e;

  typedef struct packed {
    logic [2:0][2:0][LUMA_W-1:0] luma; // [row][col]
    logic [ALPHA_W-1:0]          alpha;
    logic [ROW_W-1:0]            row;
    logic [OUT_COL_W-1:0]        col;
    logic                        last;
    logic                        frame_end;
  } job_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } q_ctl_t;
endpackage
`default_nettype wire

FILE: rtl/sem_front.sv
// front end: luma, line stores, window and job generation
`default_nettype none
module sem_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  output logic                          ready_o,
  input  wire logic [31:0]              pix_i,
  input  wire logic [sem_pkg::COL_W-1:0] width_i,
  input  wire logic [sem_pkg::HGT_W-1:0] height_i,
  input  wire logic                     restart_i,
  input  wire logic                     full_i,
  output logic                          push_o,
  output sem_pkg::job_t                 job_o
);
  import sem_pkg::*;
  localparam int AW = $clog2(MAX_WIDTH);

  front_state_e state_q, state_d;
  logic [WORD_W-1:0] upper_mem [MAX_WIDTH];
  logic [WORD_W-1:0] lower_mem [MAX_WIDTH];
  logic [WORD_W-1:0] up_rd_q, lo_rd_q, cur_q, cur_d;
  logic [2:0][2:0][WORD_W-1:0] win_q, win_d;
  logic [ROW_W-1:0] row_q, row_d, r_q, r_d, r_eff;
  logic [COL_W-1:0] col_q, col_d, c_q, c_d, c_eff, c_inc;
  logic [3:0] mask_q, mask_d, mask_new, sel;
  logic [LUMA_W-1:0] luma;
  logic accept;
  logic [2:0][1:0] rs, cs;
  logic sa, sb;

  assign c_eff  = (col_q >= width_i) ? '0 : col_q;
  assign r_eff  = (row_q >= height_i) ? '0 : row_q;
  assign accept = valid_i && ready_o;
  assign luma   = LUMA_W'(Y_R * pix_i[7:0]) + LUMA_W'(Y_G * pix_i[15:8])
                + LUMA_W'(Y_B * pix_i[23:16]);
  assign c_inc  = c_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      up_rd_q <= upper_mem[AW'(c_eff)];
      lo_rd_q <= lower_mem[AW'(c_eff)];
    end
    if (state_q == F_SHIFT) begin
      upper_mem[AW'(c_q)] <= lo_rd_q;
      lower_mem[AW'(c_q)] <= cur_q;
    end
  end

  // job mask in a-major order: bit {a,b}
  always_comb begin
    mask_new[0] = (r_q != '0) && (c_q != '0);
    mask_new[1] = (r_q != '0) && (c_q == width_i - 1'b1);
    mask_new[2] = (r_q == height_i - 1'b1) && (c_q != '0);
    mask_new[3] = (r_q == height_i - 1'b1) && (c_q == width_i - 1'b1);
  end

  always_comb begin
    sel = 4'b0000;
    if (mask_q[0])      sel = 4'b0001;
    else if (mask_q[1]) sel = 4'b0010;
    else if (mask_q[2]) sel = 4'b0100;
    else if (mask_q[3]) sel = 4'b1000;
  end

  assign push_o  = (state_q == F_EMIT) && !full_i && (mask_q != '0);
  assign ready_o = (state_q == F_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE:  if (accept) state_d = F_SHIFT;
      F_SHIFT: state_d = (mask_new == '0) ? F_IDLE : F_EMIT;
      F_EMIT:  if (push_o && ((mask_q & ~sel) == '0)) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    r_d    = r_q;
    c_d    = c_q;
    cur_d  = cur_q;
    win_d  = win_q;
    mask_d = mask_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          r_d   = r_eff;
          c_d   = c_eff;
          cur_d = {pix_i[31:24], luma};
        end
      end
      F_SHIFT: begin
        win_d[0] = win_q[1];
        win_d[1] = win_q[2];
        win_d[2] = {cur_q, lo_rd_q, up_rd_q};
        mask_d   = mask_new;
        if (c_inc >= width_i) begin
          col_d = '0;
          row_d = (r_q + 1'b1 >= height_i) ? '0 : r_q + 1'b1;
        end else begin
          col_d = c_inc;
          row_d = r_q;
        end
      end
      F_EMIT: if (push_o) mask_d = mask_q & ~sel;
      default: ;
    endcase
    if (restart_i) begin
      row_d = '0;
      col_d = '0;
    end
  end

  // clamped row and column selectors for the chosen job
  always_comb begin
    sa = sel[2] || sel[3];
    sb = sel[1] || sel[3];
    if (!sa) rs = {2'd2, 2'd1, (r_q == 16'd1) ? 2'd1 : 2'd0};
    else     rs = {2'd2, 2'd2, (r_q == '0) ? 2'd2 : 2'd1};
    if (!sb) cs = {2'd2, 2'd1, (c_q == 12'd1) ? 2'd1 : 2'd0};
    else     cs = {2'd2, 2'd2, (c_q == '0) ? 2'd2 : 2'd1};
    for (int i = 0; i < 3; i++) begin
      for (int m = 0; m < 3; m++) begin
        job_o.luma[i][m] = win_q[cs[m]][rs[i]][LUMA_W-1:0];
      end
    end
    job_o.alpha     = win_q[cs[1]][rs[1]][WORD_W-1:LUMA_W];
    job_o.row       = sa ? r_q : r_q - 1'b1;
    job_o.col       = OUT_COL_W'(sb ? c_q : c_q - 1'b1);
    job_o.last      = ((mask_q & ~sel) == '0);
    job_o.frame_end = sa && sb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      win_q   <= '0;
      mask_q  <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      win_q   <= win_d;
      mask_q  <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    c_q   <= c_d;
    cur_q <= cur_d;
  end
endmodule
`default_nettype wire

FILE: rtl/sem_queue.sv
// short job queue between front and back
`default_nettype none
module sem_queue (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  sem_pkg::job_t data_i,
  input  wire logic     pop_i,
  output sem_pkg::job_t data_o,
  output logic          full_o,
  output logic          empty_o
);
  import sem_pkg::*;
  job_t entry_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QPTR_W+1)'(push_i) - (QPTR_W+1)'(pop_i);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sem_back.sv
// back end: sobel gradients, square root, scale and result register
`default_nettype none
module sem_back (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     empty_i,
  input  sem_pkg::job_t job_i,
  output logic          pop_o,
  output logic          valid_o,
  input  wire logic     ready_i,
  output logic [7:0]    edge_o,
  output logic [7:0]    alpha_o,
  output logic [15:0]   row_o,
  output logic [10:0]   col_o,
  output logic          last_o,
  output logic          frame_end_o
);
  import sem_pkg::*;
  back_state_e state_q, state_d;
  job_t job_q;
  logic [GRAD_W-1:0] ax_q, ay_q;
  logic [2*GRAD_W-1:0] sq_x, sq_y;
  logic signed [GRAD_W:0] gx, gy;
  logic [SUM_W:0] rad_q, rad_d;
  logic [REM_W-1:0] rem_q, rem_d, rem_sh, trial;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [4:0] it_q, it_d;
  logic [DIV_SH+8:0] prod_q;
  logic cap_q, slot_free, load;
  logic [7:0] edge_val;

  function automatic logic signed [GRAD_W:0] ext(input logic [LUMA_W-1:0] v);
    return (GRAD_W+1)'(signed'({1'b0, v}));
  endfunction

  always_comb begin
    gx = ext(job_q.luma[0][2]) - ext(job_q.luma[0][0])
       + ((ext(job_q.luma[1][2]) - ext(job_q.luma[1][0])) <<< 1)
       + ext(job_q.luma[2][2]) - ext(job_q.luma[2][0]);
    gy = ext(job_q.luma[0][0]) - ext(job_q.luma[2][0])
       + ((ext(job_q.luma[0][1]) - ext(job_q.luma[2][1])) <<< 1)
       + ext(job_q.luma[0][2]) - ext(job_q.luma[2][2]);
  end

  // full-width squares of the gradient magnitudes
  assign sq_x = ax_q * ax_q;
  assign sq_y = ay_q * ay_q;

  // one root bit per cycle
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[SUM_W:SUM_W-1]};
  assign trial  = {root_q, 2'b01};
  always_comb begin
    rad_d  = {rad_q[SUM_W-2:0], 2'b00};
    it_d   = it_q + 1'b1;
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_q[ROOT_W-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_q[ROOT_W-2:0], 1'b0};
    end
  end

  assign slot_free = !valid_o || ready_i;
  assign pop_o     = (state_q == B_IDLE) && !empty_i;
  assign load      = (state_q == B_SCALE) && slot_free;
  assign edge_val  = cap_q ? 8'hFF : prod_q[DIV_SH+7:DIV_SH];

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE:  if (pop_o) state_d = B_GRAD;
      B_GRAD:  state_d = B_SQR;
      B_SQR:   state_d = B_ROOT;
      B_ROOT:  if (it_q == 5'(ROOT_W - 1)) state_d = B_DIV;
      B_DIV:   state_d = B_SCALE;
      B_SCALE: if (slot_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: if (pop_o) job_q <= job_i;
      B_GRAD: begin
        ax_q <= GRAD_W'(gx[GRAD_W] ? -gx : gx);
        ay_q <= GRAD_W'(gy[GRAD_W] ? -gy : gy);
      end
      B_SQR: begin
        rad_q  <= (SUM_W+1)'(sq_x) + (SUM_W+1)'(sq_y);
        rem_q  <= '0;
        root_q <= '0;
        it_q   <= '0;
      end
      B_ROOT: begin
        rad_q  <= rad_d;
        rem_q  <= rem_d;
        root_q <= root_d;
        it_q   <= it_d;
      end
      B_DIV: begin
        cap_q  <= (root_q >= CAP_LIMIT);
        prod_q <= (DIV_SH+9)'(root_q[LUMA_W-1:0] * DIV_K);
      end
      default: ;
    endcase
    if (load) begin
      edge_o      <= edge_val;
      alpha_o     <= job_q.alpha;
      row_o       <= job_q.row;
      col_o       <= job_q.col;
      last_o      <= job_q.last;
      frame_end_o <= job_q.frame_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) valid_o <= 1'b1;
      else if (ready_i) valid_o <= 1'b0;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sobel_edge_magnitude.sv
// top level of the sobel edge magnitude block
`default_nettype none
// Sobel 3x3 gradient magnitude over a raster RGBA stream. Each pixel goes
// through the front end in steps (accept with line store read, then window
// shift and store write, then one emit step per result pushed), and no new
// pixel is taken until the front end is through with the last one. Results
// come from an iterative integer square root in the back end, one job at a
// time, which sets the sustained rate once the four-entry job queue fills.
// Output lags input by one row and one column; the last pixel of a row or
// frame flushes its pending results. Any register write restarts the frame.
`include "sobel_edge_magnitude_assert.svh"
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH = sem_pkg::DEFAULT_MAX_WIDTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // red, green, blue, alpha
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [47:0]      m_axis_tdata_o,  // edge_value, alpha_out, out_row, out_col, pad
  output logic             m_axis_tlast_o,
  output logic [0:0]       m_axis_tuser_o,  // frame_end
  input  wire logic        psel_i,
  input  wire logic        penable_i,
  input  wire logic        pwrite_i,
  input  wire logic [2:0]  paddr_i,
  input  wire logic [31:0] pwdata_i,
  output logic [31:0]      prdata_o,
  output logic             pready_o
);
  import sem_pkg::*;

  logic [COL_W-1:0] width_q, w_eff;
  logic [HGT_W-1:0] height_q, h_eff;
  logic wr_en;
  reg_idx_e idx;
  q_ctl_t qc;
  job_t job_in, job_out;
  logic [7:0] edge_v, alpha_v;
  logic [15:0] row_v;
  logic [10:0] col_v;
  logic fe_v;

  assign pready_o = 1'b1;
  assign idx      = reg_idx_e'(paddr_i[2]);
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign prdata_o = (idx == REG_HEIGHT) ? 32'(height_q) : 32'(width_q);

  // clamp the width to the line store depth, zero acts as one
  assign w_eff = (width_q == '0) ? COL_W'(1)
               : ((14'(width_q) > 14'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH) : width_q);
  assign h_eff = (height_q == '0) ? HGT_W'(1) : height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_WIDTH:  width_q  <= pwdata_i[COL_W-1:0];
        REG_HEIGHT: height_q <= pwdata_i[HGT_W-1:0];
        default: ;
      endcase
    end
  end

  sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .pix_i     (s_axis_tdata_i),
    .width_i   (w_eff),
    .height_i  (h_eff),
    .restart_i (wr_en),
    .full_i    (qc.full),
    .push_o    (qc.push),
    .job_o     (job_in)
  );

  // decoupling queue: front stalls only when it fills
  sem_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (qc.push),
    .data_i  (job_in),
    .pop_i   (qc.pop),
    .data_o  (job_out),
    .full_o  (qc.full),
    .empty_o (qc.empty)
  );

  sem_back u_back (
    .clk_i, .rst_ni,
    .empty_i     (qc.empty),
    .job_i       (job_out),
    .pop_o       (qc.pop),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .edge_o      (edge_v),
    .alpha_o     (alpha_v),
    .row_o       (row_v),
    .col_o       (col_v),
    .last_o      (m_axis_tlast_o),
    .frame_end_o (fe_v)
  );

  assign m_axis_tdata_o = {5'b0, col_v, row_v, alpha_v, edge_v};
  assign m_axis_tuser_o = fe_v;

  `SEM_ASSERT_IMP(a_no_overflow, clk_i, rst_ni, qc.push, !qc.full)
  `SEM_ASSERT_IMP(a_no_underflow, clk_i, rst_ni, qc.pop, !qc.empty)
  `SEM_ASSERT_IMP(a_frame_end_last, clk_i, rst_ni, m_axis_tvalid_o && fe_v, m_axis_tlast_o)
  `SEM_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni,
                   s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
endmodule
`default_nettype wire

FILE: sim/sobel_edge_magnitude_test.sv
// self-checking stream testbench for the sobel edge magnitude block
`timescale 1ns / 100ps
`default_nettype none
module sobel_edge_magnitude_test;
  import sem_pkg::*;

  typedef struct packed {
    logic [7:0]  edge_value;
    logic [7:0]  alpha_out;
    logic [15:0] out_row;
    logic [10:0] out_col;
    logic        last;
    logic        frame_end;
  } edge_px_t;

  localparam int LIMIT_CYCLES = 900000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [31:0] in_data = '0;
  logic out_ready = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  wire in_ready, out_valid, out_last, pready;
  wire [47:0] out_data;
  wire [0:0] out_user;
  wire [31:0] prdata;

  always #2 clk = ~clk;

  sobel_edge_magnitude dut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid_i(in_valid), .s_axis_tready_o(in_ready), .s_axis_tdata_i(in_data),
    .m_axis_tvalid_o(out_valid), .m_axis_tready_i(out_ready), .m_axis_tdata_o(out_data),
    .m_axis_tlast_o(out_last), .m_axis_tuser_o(out_user),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_o(prdata), .pready_o(pready)
  );

  // predictor state, mirrors the block's line stores and window
  logic [25:0] upper_line [2048];
  logic [25:0] lower_line [2048];
  logic [25:0] win [3][3];   // [column slot][upper, lower, current]
  int unsigned cfg_width = 640, cfg_height = 480;
  int unsigned row_pos = 0, col_pos = 0;

  logic [31:0] pixel_queue [$];   // pending input transactions
  edge_px_t    edge_queue [$];    // expected output transactions
  int errors = 0;
  int send_idle_pct = 20, recv_idle_pct = 56;
  bit send_hold = 1'b0;
  int recv_hold_cycles = 0;
  int cycle_count = 0;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bit_v;
    res = 0; bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  function automatic logic [7:0] grad_mag(int cs[3], int rs[3]);
    longint gx, gy, m;
    longint wgt[3];
    wgt = '{1, 2, 1};
    gx = 0; gy = 0;
    for (int i = 0; i < 3; i++) begin
      gx += wgt[i] * (longint'(win[cs[2]][rs[i]][17:0]) - longint'(win[cs[0]][rs[i]][17:0]));
      gy += wgt[i] * (longint'(win[cs[i]][rs[0]][17:0]) - longint'(win[cs[i]][rs[2]][17:0]));
    end
    m = isqrt(gx * gx + gy * gy) / 1000;
    return (m > 255) ? 8'd255 : m[7:0];
  endfunction

  // advance the predictor by one pixel and queue the edge pixels it releases
  task automatic predict_pixel(logic [31:0] px);
    int unsigned w, h, r, c, nr, nc, n;
    int unsigned rows[2], cols[2];
    int rsel[2][3], csel[2][3];
    logic [25:0] word, up, lo;
    edge_px_t e;
    w = (cfg_width == 0) ? 1 : (cfg_width > 2048 ? 2048 : cfg_width);
    h = (cfg_height == 0) ? 1 : cfg_height;
    r = (row_pos >= h) ? 0 : row_pos;
    c = (col_pos >= w) ? 0 : col_pos;
    nr = 0; nc = 0; n = 0;
    word[17:0] = 18'(299 * px[7:0] + 587 * px[15:8] + 114 * px[23:16]);
    word[25:18] = px[31:24];
    up = upper_line[c]; lo = lower_line[c];
    upper_line[c] = lo; lower_line[c] = word;
    win[0] = win[1]; win[1] = win[2];
    win[2][0] = up; win[2][1] = lo; win[2][2] = word;
    if (r >= 1) begin
      rows[nr] = r - 1; rsel[nr] = '{(r == 1) ? 1 : 0, 1, 2}; nr++;
    end
    if (r == h - 1) begin
      rows[nr] = r; rsel[nr] = '{(r == 0) ? 2 : 1, 2, 2}; nr++;
    end
    if (c >= 1) begin
      cols[nc] = c - 1; csel[nc] = '{(c == 1) ? 1 : 0, 1, 2}; nc++;
    end
    if (c == w - 1) begin
      cols[nc] = c; csel[nc] = '{(c == 0) ? 2 : 1, 2, 2}; nc++;
    end
    for (int a = 0; a < nr; a++) begin
      for (int b = 0; b < nc; b++) begin
        e.edge_value = grad_mag(csel[b], rsel[a]);
        e.alpha_out = win[csel[b][1]][rsel[a][1]][25:18];
        e.out_row = rows[a][15:0];
        e.out_col = cols[b][10:0];
        e.last = (a == nr - 1) && (b == nc - 1);
        e.frame_end = (rows[a] == h - 1) && (cols[b] == w - 1);
        edge_queue.push_back(e);
        n++;
      end
    end
    c++;
    if (c >= w) begin
      c = 0; r++;
      if (r >= h) r = 0;
    end
    row_pos = r; col_pos = c;
  endtask

  // driver: offers queued pixels, holding data until the transaction completes
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_pixel(in_data);
        void'(pixel_queue.pop_front());
      end
      if ((!in_valid || in_ready)) begin
        if (in_valid && in_ready && pixel_queue.size() == 0) in_valid <= 1'b0;
        else if (pixel_queue.size() > 0 && !send_hold &&
                 $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= (in_valid && in_ready) ? pixel_queue[0] : pixel_queue[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each output transaction with the oldest expectation
  always @(posedge clk) begin
    edge_px_t got, want;
    if (rst_n) begin
      cycle_count <= cycle_count + 1;
      if (out_valid && out_ready) begin
        got = {out_data[7:0], out_data[15:8], out_data[31:16], out_data[42:32],
               out_last, out_user[0]};
        if (edge_queue.size() == 0) begin
          $display("%0t: unexpected output, actual %p", $time, got);
          errors++;
        end else begin
          want = edge_queue.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected %p actual %p", $time, want, got);
            errors++;
          end
        end
      end
      if (recv_hold_cycles > 0) begin
        recv_hold_cycles <= recv_hold_cycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_count > LIMIT_CYCLES) begin
      $display("sobel_edge_magnitude test failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pixel_queue.size() > 0 || in_valid) @(posedge clk);
    while (edge_queue.size() > 0) @(posedge clk);
    // pixels that release nothing may still be in flight
    repeat (200) @(posedge clk);
  endtask

  // apb write, then restart the predictor's frame
  task automatic write_reg(reg_idx_e idx, int unsigned value);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 3'(4 * int'(idx)); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_WIDTH) cfg_width = value & 12'hFFF;
    else cfg_height = value & 16'hFFFF;
    row_pos = 0; col_pos = 0;
  endtask

  function automatic logic [31:0] rand_pixel();
    return $urandom;
  endfunction

  task automatic run_frame(int unsigned w, int unsigned h, int frames);
    int unsigned pix_count;
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    // zero sizes act as one
    pix_count = frames * ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
    for (int i = 0; i < pix_count; i++) pixel_queue.push_back(rand_pixel());
    wait_drained();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes of every channel on a 3x3 frame, then degenerate sizes
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 3);
    pixel_queue.push_back(32'hFFFF_FFFF); pixel_queue.push_back(32'h0000_0000);
    pixel_queue.push_back(32'hFF00_00FF); pixel_queue.push_back(32'h00FF_FF00);
    pixel_queue.push_back(32'hFFFF_FFFF); pixel_queue.push_back(32'h0000_0000);
    pixel_queue.push_back(32'h0000_0000); pixel_queue.push_back(32'hFFFF_FFFF);
    pixel_queue.push_back(32'h8000_FF00);
    wait_drained();
    run_frame(1, 1, 2);    // single pixel frame
    run_frame(1, 3, 1);    // single column
    run_frame(4, 1, 1);    // single row
    run_frame(0, 0, 1);    // zero acts as one
    // random phases with different idling patterns
    send_idle_pct = 20; recv_idle_pct = 56;
    run_frame(7, 5, 2);
    run_frame(12, 4, 1);   // wider frame
    send_idle_pct = 56; recv_idle_pct = 20;
    run_frame(5, 6, 2);
    // long receiver hold-off so the block stalls its input
    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(REG_WIDTH, 9);
    write_reg(REG_HEIGHT, 4);
    recv_hold_cycles = 400;
    for (int i = 0; i < 36; i++) pixel_queue.push_back(rand_pixel());
    wait_drained();
    // sender pause until drained, mid frame
    for (int i = 0; i < 18; i++) pixel_queue.push_back(rand_pixel());
    send_hold = 1'b0;
    while (pixel_queue.size() > 0 || in_valid) @(posedge clk);
    send_hold = 1'b1;
    while (edge_queue.size() > 0) @(posedge clk);
    send_hold = 1'b0;
    for (int i = 0; i < 18; i++) pixel_queue.push_back(rand_pixel());
    wait_drained();
    run_frame(8, 8, 1);
    run_frame(640, 480, 0);  // back to reset values, no pixels
    repeat (300) @(posedge clk);
    if (errors == 0 && edge_queue.size() == 0) begin
      $display("sobel_edge_magnitude test passed");
    end else begin
      $display("sobel_edge_magnitude test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
